FILE: src/itps_pkg.sv
// ----------------------------------------------------------------------------
// itps_pkg
// Types and constants shared by the transport-protocol frame segmenter.
// ----------------------------------------------------------------------------
package itps_pkg;

    localparam int unsigned DATA_W  = 8;
    localparam int unsigned LEN_W   = 12;
    localparam int unsigned FRAME_W = 64;
    localparam int unsigned POS_W   = 3;
    localparam int unsigned SEQ_W   = 4;

    // Protocol control nibbles and limits
    localparam logic [3:0]       PCI_FIRST  = 4'h1;
    localparam logic [3:0]       PCI_CONSEC = 4'h2;
    localparam logic [LEN_W-1:0] SF_MAX     = 12'd7;
    localparam logic [LEN_W-1:0] FF_DATA    = 12'd6;
    localparam logic [POS_W-1:0] POS_LAST   = 3'd7;
    localparam logic [POS_W-1:0] POS_SF     = 3'd1;
    localparam logic [POS_W-1:0] POS_FF     = 3'd2;

    typedef enum logic [1:0] {
        KIND_SINGLE = 2'd0,
        KIND_FIRST  = 2'd1,
        KIND_CONSEC = 2'd2
    } t_frame_kind;

    // One registered input request
    typedef struct packed {
        logic [DATA_W-1:0] data_byte;
        logic [LEN_W-1:0]  message_length;
    } t_item;

    // Input stage towards frame builder
    typedef struct packed {
        logic  valid;
        t_item item;
    } t_stage;

endpackage

FILE: src/itps_if.sv
// ----------------------------------------------------------------------------
// itps_in_if / itps_out_if
// Valid/ready channels for payload bytes in and frames out.
// ----------------------------------------------------------------------------
interface itps_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  data_byte;
    logic [11:0] message_length;

    modport source (output valid, output data_byte, output message_length, input ready);
    modport sink   (input valid, input data_byte, input message_length, output ready);
endinterface

interface itps_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] frame_bytes;
    logic [1:0]  frame_kind;
    logic        last_frame;

    modport source (output valid, output frame_bytes, output frame_kind,
                    output last_frame, input ready);
    modport sink   (input valid, input frame_bytes, input frame_kind,
                    input last_frame, output ready);
endinterface

FILE: src/iso_tp_frame_segmenter.sv
// ----------------------------------------------------------------------------
// iso_tp_frame_segmenter
// Splits a byte stream into 8-byte transport-protocol frames.
// ----------------------------------------------------------------------------
// Usage:
//   i_req carries one payload byte per request, with message_length sampled
//   only on the first byte of a message (a zero length drops that byte).
//   o_rsp carries complete frames: the eight frame bytes (byte 0 in the top
//   bits), the frame kind and a last-frame flag.
//   Messages of 1..7 bytes give one single frame; longer messages give a
//   first frame followed by consecutive frames with a wrapping sequence.
// Throughput and path:
//   One byte is taken every cycle while i_req.ready is high. A frame reaches
//   o_rsp through the input register and then the frame builder, whose result
//   register drives o_rsp.
// Reset:
//   Synchronous, active low; no message is open and both channels are empty.
// Stalls:
//   While o_rsp is held off, bytes that do not complete a frame still flow
//   in; a byte that would finish the next frame waits in the input register
//   and i_req.ready drops until the output register is freed.
// ----------------------------------------------------------------------------
module iso_tp_frame_segmenter
    import itps_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    itps_in_if.sink           i_req,
    itps_out_if.source        o_rsp
);

    t_item       req_item;
    t_stage      stage;
    logic        take;
    t_frame_kind frame_kind;

    assign req_item.data_byte      = i_req.data_byte;
    assign req_item.message_length = i_req.message_length;

    itps_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_req.valid),
        .o_ready (i_req.ready),
        .i_item  (req_item),
        .o_stage (stage),
        .i_take  (take)
    );

    itps_frame_build u_frame_build (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_stage       (stage),
        .o_take        (take),
        .o_valid       (o_rsp.valid),
        .i_ready       (o_rsp.ready),
        .o_frame_bytes (o_rsp.frame_bytes),
        .o_frame_kind  (frame_kind),
        .o_last_frame  (o_rsp.last_frame)
    );

    assign o_rsp.frame_kind = frame_kind;

endmodule

FILE: src/itps_in_reg.sv
// ----------------------------------------------------------------------------
// itps_in_reg
// Input register: captures one byte request per cycle while o_ready is high and hands it on.
// ----------------------------------------------------------------------------
module itps_in_reg
    import itps_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    output logic   o_ready,
    input  t_item  i_item,
    output t_stage o_stage,
    input  logic   i_take
);

    logic  r_valid;
    t_item r_item;

    // Accept when empty or when the held request moves on this cycle
    assign o_ready = !r_valid || i_take;

    // Hold the valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Capture the payload
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

    assign o_stage.valid = r_valid;
    assign o_stage.item  = r_item;

endmodule

FILE: src/itps_frame_build.sv
// ----------------------------------------------------------------------------
// itps_frame_build
// Frame assembly state and result register: places each byte into the
// frame being filled and loads complete frames into the output register.
// ----------------------------------------------------------------------------
module itps_frame_build
    import itps_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_stage             i_stage,
    output logic               o_take,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [FRAME_W-1:0] o_frame_bytes,
    output t_frame_kind        o_frame_kind,
    output logic               o_last_frame
);

    logic [LEN_W-1:0]   r_remaining, n_remaining;
    logic [LEN_W-1:0]   r_held,      n_held;
    logic [FRAME_W-1:0] r_buf,       n_buf;
    logic [POS_W-1:0]   r_pos,       n_pos;
    logic [SEQ_W-1:0]   r_seq,       n_seq;

    logic               r_out_valid;
    logic [FRAME_W-1:0] r_out_bytes;
    t_frame_kind        r_out_kind;
    logic               r_out_last;

    logic               msg_open;
    logic               is_sf;
    logic               drop;
    logic [LEN_W-1:0]   len;
    logic [LEN_W-1:0]   base_rem;
    logic [LEN_W-1:0]   base_held;
    logic [FRAME_W-1:0] base_buf;
    logic [POS_W-1:0]   base_pos;
    logic [SEQ_W-1:0]   base_seq;
    logic [FRAME_W-1:0] buf_w;
    logic [LEN_W-1:0]   rem_dec;
    logic               done;
    logic               emit;
    logic               advance;
    t_frame_kind        kind;

    // Open a new message when nothing is outstanding
    assign len      = i_stage.item.message_length;
    assign msg_open = (r_remaining == '0);
    assign is_sf    = (len <= SF_MAX);
    assign drop     = msg_open && (len == '0);

    always_comb begin
        if (msg_open) begin
            base_rem  = len;
            base_held = len;
            if (is_sf) begin
                base_buf = {len[7:0], 56'd0};
                base_pos = POS_SF;
                base_seq = r_seq;
            end else begin
                base_buf = {PCI_FIRST, len, 48'd0};
                base_pos = POS_FF;
                base_seq = SEQ_W'(1);
            end
        end else begin
            base_rem  = r_remaining;
            base_held = r_held;
            base_buf  = r_buf;
            base_pos  = r_pos;
            base_seq  = r_seq;
        end
    end

    // Place the byte at its slot and count it off
    assign buf_w   = base_buf | ({56'd0, i_stage.item.data_byte}
                                 << {(POS_LAST - base_pos), 3'b000});
    assign rem_dec = base_rem - LEN_W'(1);
    assign done    = (rem_dec == '0);
    assign emit    = !drop && ((base_pos == POS_LAST) || done);

    always_comb begin
        if (base_held <= SF_MAX) begin
            kind = KIND_SINGLE;
        end else if ((base_held - rem_dec) == FF_DATA) begin
            kind = KIND_FIRST;
        end else begin
            kind = KIND_CONSEC;
        end
    end

    // Advance unless a frame is due and the output register cannot take it
    assign advance = i_stage.valid && (!emit || !r_out_valid || i_ready);
    assign o_take  = advance;

    // Next frame state
    always_comb begin
        n_remaining = r_remaining;
        n_held      = r_held;
        n_buf       = r_buf;
        n_pos       = r_pos;
        n_seq       = r_seq;
        if (advance && !drop) begin
            n_remaining = rem_dec;
            if (!emit) begin
                n_held = base_held;
                n_buf  = buf_w;
                n_pos  = base_pos + POS_W'(1);
                n_seq  = base_seq;
            end else if (done) begin
                n_held = '0;
                n_buf  = '0;
                n_pos  = '0;
                n_seq  = base_seq;
            end else begin
                n_held = base_held;
                n_buf  = {PCI_CONSEC, base_seq, 56'd0};
                n_pos  = POS_SF;
                n_seq  = base_seq + SEQ_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_remaining <= '0;
            r_held      <= '0;
            r_buf       <= '0;
            r_pos       <= '0;
            r_seq       <= '0;
        end else begin
            r_remaining <= n_remaining;
            r_held      <= n_held;
            r_buf       <= n_buf;
            r_pos       <= n_pos;
            r_seq       <= n_seq;
        end
    end

    // Result register: load a finished frame, drop the flag once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && emit) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && emit) begin
            r_out_bytes <= buf_w;
            r_out_kind  <= kind;
            r_out_last  <= done;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_frame_bytes = r_out_bytes;
    assign o_frame_kind  = r_out_kind;
    assign o_last_frame  = r_out_last;

endmodule

FILE: src/itps_checker.sv
// ----------------------------------------------------------------------------
// itps_checker
// Port-level checks on the frames leaving the segmenter.
// ----------------------------------------------------------------------------
module itps_checker
    import itps_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        i_ready,
    input logic [63:0] i_frame_bytes,
    input logic [1:0]  i_frame_kind,
    input logic        i_last_frame
);

    // Hold a stalled frame
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_frame_bytes))
        else $error("stalled frame changed");

    // A single frame always closes its message
    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && (i_frame_kind == KIND_SINGLE) |-> i_last_frame)
        else $error("single frame not marked last");

    // A first frame never closes its message and carries its nibble
    a_first_hdr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && (i_frame_kind == KIND_FIRST)
        |-> !i_last_frame && (i_frame_bytes[63:60] == PCI_FIRST))
        else $error("bad first frame");

    // A consecutive frame carries its nibble
    a_consec_hdr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && (i_frame_kind == KIND_CONSEC)
        |-> (i_frame_bytes[63:60] == PCI_CONSEC))
        else $error("bad consecutive frame header");

    // A single frame header holds a length of 1 to 7
    a_single_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && (i_frame_kind == KIND_SINGLE)
        |-> (i_frame_bytes[63:59] == 5'd0) && (i_frame_bytes[58:56] != 3'd0))
        else $error("bad single frame length");

endmodule

bind iso_tp_frame_segmenter itps_checker u_itps_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (o_rsp.valid),
    .i_ready       (o_rsp.ready),
    .i_frame_bytes (o_rsp.frame_bytes),
    .i_frame_kind  (o_rsp.frame_kind),
    .i_last_frame  (o_rsp.last_frame)
);

FILE: test/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the transport-protocol frame segmenter. Payload
// bytes are pushed in as whole messages of random length. A frame tracker
// rebuilds every frame from the accepted requests. Each frame that leaves
// the block is compared with the oldest frame still owed. Random messages
// run in three phases; both handshakes stall at random in the first two.
// ----------------------------------------------------------------------------
module tb_top;
    import itps_pkg::*;

    localparam int unsigned STALL_LIMIT  = 4000;
    localparam int unsigned PHASE_BYTES  = 200;
    localparam int unsigned REPORT_FIRST = 10;

    typedef struct {
        logic [FRAME_W-1:0] bytes;
        t_frame_kind        kind;
        logic               last;
    } t_frame;

    // Rebuild frames from accepted bytes and hold those still owed
    class tp_frame_tracker;
        logic [LEN_W-1:0]   bytes_left;
        logic [LEN_W-1:0]   open_length;
        logic [FRAME_W-1:0] frame_fill;
        logic [POS_W-1:0]   slot;
        logic [SEQ_W-1:0]   next_seq;
        t_frame             pending_frames[$];
        int                 fault_count;

        function new();
            bytes_left  = '0;
            open_length = '0;
            frame_fill  = '0;
            slot        = '0;
            next_seq    = '0;
            fault_count = 0;
        endfunction

        function void take_byte(logic [DATA_W-1:0] data, logic [LEN_W-1:0] msg_len);
            t_frame           f;
            logic [POS_W-1:0] pos;
            logic             done;

            // Open a message; a zero length drops the byte
            if (bytes_left == 0) begin
                if (msg_len == 0)
                    return;
                open_length = msg_len;
                bytes_left  = msg_len;
                if (msg_len <= SF_MAX) begin
                    frame_fill = {msg_len[7:0], 56'b0};
                    slot       = POS_SF;
                end else begin
                    frame_fill = {PCI_FIRST, msg_len, 48'b0};
                    slot       = POS_FF;
                    next_seq   = 4'd1;
                end
            end

            pos        = slot;
            frame_fill = frame_fill | ({56'b0, data} << (8 * (7 - pos)));
            bytes_left = bytes_left - 1'b1;
            done       = (bytes_left == 0);

            // Hold a partial frame
            if (pos != POS_LAST && !done) begin
                slot = pos + 1'b1;
                return;
            end

            f.bytes = frame_fill;
            f.last  = done;
            if (open_length <= SF_MAX)
                f.kind = KIND_SINGLE;
            else if (open_length - bytes_left == FF_DATA)
                f.kind = KIND_FIRST;
            else
                f.kind = KIND_CONSEC;
            pending_frames.push_back(f);

            if (done) begin
                frame_fill  = '0;
                slot        = '0;
                open_length = '0;
            end else begin
                frame_fill = {PCI_CONSEC, next_seq, 56'b0};
                slot       = POS_SF;
                next_seq   = next_seq + 1'b1;
            end
        endfunction

        function void match_frame(logic [FRAME_W-1:0] bytes, logic [1:0] kind, logic last);
            t_frame want;

            if (pending_frames.size() == 0) begin
                fault_count++;
                if (fault_count <= REPORT_FIRST)
                    $display("%0t: frame %h kind %0d last %0b arrived with none owed",
                             $realtime, bytes, kind, last);
                return;
            end
            want = pending_frames.pop_front();
            if (bytes !== want.bytes || kind !== want.kind || last !== want.last) begin
                fault_count++;
                if (fault_count <= REPORT_FIRST)
                    $display("%0t: frame expected %h kind %0d last %0b, got %h kind %0d last %0b",
                             $realtime, want.bytes, want.kind, want.last, bytes, kind, last);
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    itps_in_if  req_if ();
    itps_out_if rsp_if ();

    tp_frame_tracker tracker = new();

    int unsigned src_idle_pct;
    int unsigned sink_idle_pct;
    int unsigned counted_bytes;
    int unsigned quiet_cycles;

    iso_tp_frame_segmenter dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    initial begin
        i_clk = 1'b0;
    end

    always #5 i_clk = ~i_clk;

    // Check each accepted frame, then pick the next ready level
    always @(posedge i_clk) begin
        if (i_rst_n && rsp_if.valid && rsp_if.ready)
            tracker.match_frame(rsp_if.frame_bytes, rsp_if.frame_kind, rsp_if.last_frame);
        rsp_if.ready <= ($urandom_range(99) >= sink_idle_pct);
    end

    // Abort when neither channel moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Present one request, idling first at random, and wait for acceptance
    task automatic send_byte(input logic [DATA_W-1:0] data, input logic [LEN_W-1:0] msg_len);
        while ($urandom_range(99) < src_idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid          <= 1'b1;
        req_if.data_byte      <= data;
        req_if.message_length <= msg_len;
        do @(posedge i_clk); while (!req_if.ready);
        tracker.take_byte(data, msg_len);
    endtask

    // Send a whole message; the length field is noise after the first byte
    task automatic send_message(input logic [LEN_W-1:0] msg_len);
        for (int i = 0; i < msg_len; i++)
            send_byte(DATA_W'($urandom_range(255)),
                      (i == 0) ? msg_len : LEN_W'($urandom_range(4095)));
        counted_bytes += msg_len;
    endtask

    // Drop valid and wait until every owed frame has arrived
    task automatic drain_frames();
        req_if.valid <= 1'b0;
        do @(posedge i_clk); while (tracker.pending_frames.size() != 0);
    endtask

    function automatic logic [LEN_W-1:0] pick_length();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 80)
            return LEN_W'($urandom_range(16, 1));
        else if (r < 97)
            return LEN_W'($urandom_range(130, 17));
        return LEN_W'($urandom_range(300, 131));
    endfunction

    initial begin
        logic [DATA_W-1:0] seven_bytes [7] = '{8'hFF, 8'h00, 8'hAA, 8'h55, 8'h80, 8'h01, 8'h7F};
        logic [LEN_W-1:0]  seven_lens  [7] = '{12'd7, 12'd0, 12'd4095, 12'd1, 12'd8,
                                               12'd2048, 12'd0};

        i_rst_n               = 1'b0;
        req_if.valid          = 1'b0;
        req_if.data_byte      = '0;
        req_if.message_length = '0;
        rsp_if.ready          = 1'b0;
        src_idle_pct          = 0;
        sink_idle_pct         = 0;
        counted_bytes         = 0;
        quiet_cycles          = 0;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: dropped zero-length byte, shortest and longest single frames
        // with the length changing mid-message, then a first frame plus one
        // consecutive frame
        send_byte(8'hFF, 12'd0);
        send_byte(8'h00, 12'd1);
        for (int i = 0; i < 7; i++)
            send_byte(seven_bytes[i], seven_lens[i]);
        for (int i = 0; i < 8; i++)
            send_byte((i == 0) ? 8'hFF : ((i == 7) ? 8'h00 : 8'(i)), (i == 0) ? 12'd8 : 12'd0);
        drain_frames();

        // Random messages under three stall patterns
        for (int phase = 0; phase < 3; phase++) begin
            src_idle_pct  = (phase == 0) ? 27 : ((phase == 1) ? 82 : 0);
            sink_idle_pct = (phase == 0) ? 82 : ((phase == 1) ? 27 : 0);
            counted_bytes = 0;
            while (counted_bytes < PHASE_BYTES) begin
                if ($urandom_range(14) == 0)
                    send_byte(DATA_W'($urandom_range(255)), 12'd0);
                send_message(pick_length());
            end
            drain_frames();
        end

        repeat (10) @(posedge i_clk);
        if (tracker.fault_count == 0 && tracker.pending_frames.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
